// ===== sv/btr_pkg.sv =====
package btr_pkg;

    // Font store geometry.
    localparam int STORE_DEPTH   = 768;
    localparam int FONT_ADDR_W   = 10;
    // Holds glyph * GLYPH_HEIGHT + row up to 4095; larger products are truncated.
    localparam int GLYPH_ADDR_W  = 12;
    localparam logic [7:0] FIRST_CODE = 8'h20;

    // Input item operations.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Default geometry of the font.
    localparam int DEF_GLYPH_WIDTH  = 8;
    localparam int DEF_GLYPH_HEIGHT = 8;
    localparam int DEF_GLYPH_COUNT  = 96;

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_FG_COLOR     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [15:0] RST_FG_COLOR     = 16'h0000;
    localparam logic [7:0]  RST_IMAGE_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_IMAGE_HEIGHT = 8'd128;

    typedef struct packed {
        logic capture;     // draw item transfer: hold its fields
        logic load_write;  // load item transfer: write the font store
        logic start;       // resolve origin and cursor
        logic prep;        // first row read, row base
        logic load_row;    // take the first glyph row
        logic emit;        // put one pixel into the output register
        logic row_end;     // emitted pixel closes a glyph row
        logic last;        // emitted pixel closes the character
    } t_dp_cmd;

    typedef struct packed {
        logic drop;        // character produces no pixels
        logic out_free;    // output register can take a pixel
    } t_dp_status;

endpackage

// ===== sv/btr_ram.sv =====
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/btr_ctrl.sv =====
module btr_ctrl #(
    parameter int GLYPH_WIDTH  = btr_pkg::DEF_GLYPH_WIDTH,
    parameter int GLYPH_HEIGHT = btr_pkg::DEF_GLYPH_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_operation,
    output logic               o_in_ready,
    output btr_pkg::t_dp_cmd   o_cmd,
    input  btr_pkg::t_dp_status i_status
);

    localparam int CW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int PW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PREP,
        ST_LOAD,
        ST_PIX
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [PW-1:0] r_row;
    logic [PW-1:0] n_row;
    logic          w_accept;
    logic          w_draw;
    logic          w_row_end;
    logic          w_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_draw     = (i_operation == btr_pkg::OP_DRAW);
    assign w_row_end  = (r_col == CW'(GLYPH_WIDTH - 1));
    assign w_last     = w_row_end && (r_row == PW'(GLYPH_HEIGHT - 1));

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        o_cmd   = '0;
        o_cmd.capture    = w_accept && w_draw;
        o_cmd.load_write = w_accept && !w_draw;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_draw) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state = i_status.drop ? ST_IDLE : ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load_row = 1'b1;
                n_col   = '0;
                n_row   = '0;
                n_state = ST_PIX;
            end
            ST_PIX: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.row_end = w_row_end;
                    o_cmd.last    = w_last;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else if (w_row_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

endmodule

// ===== sv/btr_dp.sv =====
module btr_dp #(
    parameter int GLYPH_WIDTH  = btr_pkg::DEF_GLYPH_WIDTH,
    parameter int GLYPH_HEIGHT = btr_pkg::DEF_GLYPH_HEIGHT,
    parameter int GLYPH_COUNT  = btr_pkg::DEF_GLYPH_COUNT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  btr_pkg::t_dp_cmd                  i_cmd,
    output btr_pkg::t_dp_status               o_status,
    input  logic                              i_cfg_valid,
    input  logic [btr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [btr_pkg::FONT_ADDR_W-1:0]   i_font_address,
    input  logic [7:0]                        i_font_byte,
    input  logic [7:0]                        i_char_code,
    input  logic                              i_first_of_string,
    input  logic [7:0]                        i_origin_x,
    input  logic [7:0]                        i_origin_y,
    input  logic [15:0]                       i_background,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [15:0]                       o_pixel_index,
    output logic [15:0]                       o_pixel_value,
    output logic                              o_write_enable,
    output logic                              o_last
);

    localparam int AW = btr_pkg::GLYPH_ADDR_W;
    localparam int FW = btr_pkg::FONT_ADDR_W;
    localparam logic [AW-1:0] STORE_END = AW'(btr_pkg::STORE_DEPTH);

    // Configuration registers.
    logic [15:0] r_fg;
    logic [7:0]  r_width;
    logic [7:0]  r_height;

    // Text cursor.
    logic [8:0]  r_cur_col;
    logic [8:0]  r_cur_row;
    logic [7:0]  r_start_col;
    logic [7:0]  r_start_row;
    logic        r_active;

    // Held draw item.
    logic [7:0]  r_code;
    logic        r_first;
    logic [7:0]  r_ox;
    logic [7:0]  r_oy;
    logic [15:0] r_bg;

    // Pixel walk.
    logic          r_glyph_ok;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_rd_addr;
    logic [7:0]    r_bits;
    logic          r_row_ok;
    logic [9:0]    r_px;
    logic [9:0]    r_py;
    logic [15:0]   r_row_base;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_index;
    logic [15:0] r_out_value;
    logic        r_out_we;
    logic        r_out_last;

    logic          w_origin_bad;
    logic          w_drop;
    logic [8:0]    w_c0;
    logic [8:0]    w_r0;
    logic [8:0]    w_sc;
    logic [8:0]    w_sr;
    logic [9:0]    w_c0_end;
    logic [9:0]    w_r0_next;
    logic          w_col_wrap;
    logic [8:0]    w_c1;
    logic [8:0]    w_r1;
    logic [9:0]    w_r1_end;
    logic          w_row_wrap;
    logic [8:0]    w_c2;
    logic [8:0]    w_r2;
    logic [7:0]    w_gidx;
    logic          w_gok;
    logic [AW-1:0] w_base;
    logic [16:0]   w_row_prod;
    logic          w_latch;
    logic [AW-1:0] w_next_addr;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;
    logic          w_wr_en;
    logic          w_inside;
    logic [15:0]   w_colour;

    // Origin check and cursor placement for a new character.
    assign w_origin_bad = (r_ox >= r_width) || (r_oy >= r_height);
    assign w_drop       = r_first ? w_origin_bad : !r_active;
    assign w_c0 = r_first ? {1'b0, r_ox} : r_cur_col;
    assign w_r0 = r_first ? {1'b0, r_oy} : r_cur_row;
    assign w_sc = {1'b0, (r_first ? r_ox : r_start_col)};
    assign w_sr = {1'b0, (r_first ? r_oy : r_start_row)};

    assign w_c0_end   = {1'b0, w_c0} + 10'(GLYPH_WIDTH);
    assign w_r0_next  = {1'b0, w_r0} + 10'(GLYPH_HEIGHT);
    assign w_col_wrap = w_c0_end > {2'b00, r_width};
    assign w_c1 = w_col_wrap ? w_sc : w_c0;
    assign w_r1 = w_col_wrap ? w_r0_next[8:0] : w_r0;
    assign w_r1_end   = {1'b0, w_r1} + 10'(GLYPH_HEIGHT);
    assign w_row_wrap = w_r1_end > {2'b00, r_height};
    assign w_c2 = w_row_wrap ? w_sc : w_c1;
    assign w_r2 = w_row_wrap ? w_sr : w_r1;

    assign w_gidx = r_code - btr_pkg::FIRST_CODE;
    assign w_gok  = (r_code >= btr_pkg::FIRST_CODE) && ({1'b0, w_gidx} < 9'(GLYPH_COUNT));
    assign w_base = w_gok ? (AW'(w_gidx) * AW'(GLYPH_HEIGHT)) : '0;

    assign w_row_prod = {8'b0, r_cur_row} * {9'b0, r_width};

    // The next glyph row is prefetched while its address lies inside the store; the RAM output holds it until taken.
    assign w_latch     = i_cmd.load_row || (i_cmd.emit && i_cmd.row_end);
    assign w_next_addr = r_rd_addr + 1'b1;
    assign w_rd_addr   = i_cmd.prep ? r_base : w_next_addr;
    assign w_rd_en     = (i_cmd.prep || w_latch) && (w_rd_addr < STORE_END);
    assign w_wr_en     = i_cmd.load_write && (i_font_address < FW'(btr_pkg::STORE_DEPTH));

    btr_ram #(
        .WIDTH (8),
        .DEPTH (btr_pkg::STORE_DEPTH)
    ) u_font (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_font_address),
        .i_wr_data (i_font_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr[FW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_inside = (r_px < {2'b00, r_width}) && (r_py < {2'b00, r_height});
    assign w_colour = r_bits[7] ? r_fg : r_bg;

    assign o_status.drop     = w_drop;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg        <= btr_pkg::RST_FG_COLOR;
            r_width     <= btr_pkg::RST_IMAGE_WIDTH;
            r_height    <= btr_pkg::RST_IMAGE_HEIGHT;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_start_col <= '0;
            r_start_row <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    btr_pkg::CFG_FG_COLOR:     r_fg     <= i_cfg_data;
                    btr_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[7:0];
                    btr_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_cmd.start) begin
                if (r_first) begin
                    r_active <= !w_origin_bad;
                end
                if (!w_drop) begin
                    r_cur_col <= w_c2;
                    r_cur_row <= w_r2;
                    if (r_first) begin
                        r_start_col <= r_ox;
                        r_start_row <= r_oy;
                    end
                end
            end else if (i_cmd.emit && i_cmd.last) begin
                r_cur_col <= r_cur_col + 9'(GLYPH_WIDTH);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code  <= i_char_code;
            r_first <= i_first_of_string;
            r_ox    <= i_origin_x;
            r_oy    <= i_origin_y;
            r_bg    <= i_background;
        end

        if (i_cmd.start) begin
            r_glyph_ok <= w_gok;
            r_base     <= w_base;
        end

        if (i_cmd.prep) begin
            r_rd_addr  <= r_base;
            r_row_base <= w_row_prod[15:0];
            r_px       <= {1'b0, r_cur_col};
            r_py       <= {1'b0, r_cur_row};
        end

        if (w_latch) begin
            r_row_ok  <= r_glyph_ok && (r_rd_addr < STORE_END);
            r_bits    <= (r_glyph_ok && (r_rd_addr < STORE_END)) ? w_rd_data : 8'h00;
            r_rd_addr <= w_next_addr;
        end else if (i_cmd.emit) begin
            r_bits <= {r_bits[6:0], 1'b0};
        end

        if (i_cmd.emit) begin
            r_out_index <= {6'b0, r_px} + r_row_base;
            r_out_value <= {w_colour[7:0], w_colour[15:8]};
            r_out_we    <= w_inside && r_row_ok;
            r_out_last  <= i_cmd.last;
            if (i_cmd.row_end) begin
                r_px       <= {1'b0, r_cur_col};
                r_py       <= r_py + 1'b1;
                r_row_base <= r_row_base + {8'b0, r_width};
            end else begin
                r_px <= r_px + 1'b1;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_index  = r_out_index;
    assign o_pixel_value  = r_out_value;
    assign o_write_enable = r_out_we;
    assign o_last         = r_out_last;

endmodule

// ===== sv/bitmap_text_renderer_unit.sv =====
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_operation, i_font_address, i_font_byte, i_char_code,
//                                      i_first_of_string, i_origin_x, i_origin_y, i_background
// output    o_out_valid / i_out_ready  o_pixel_index, o_pixel_value, o_write_enable, o_last
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load item writes the font store in the cycle of its transfer, if its address lies in the store.
// A drawn character passes the setup states START (cursor), PREP (first font row read) and
// LOAD (first row taken), then one pixel per cycle while the output can take it, paced by
// the single output register; the next glyph row is prefetched from the font RAM.
// A dropped character goes from START back to idle. Output stalls hold the pixel walk in place.
// Reset is synchronous; the font store keeps its contents and needs no clearing.
module bitmap_text_renderer_unit #(
    parameter int GLYPH_WIDTH  = btr_pkg::DEF_GLYPH_WIDTH,
    parameter int GLYPH_HEIGHT = btr_pkg::DEF_GLYPH_HEIGHT,
    parameter int GLYPH_COUNT  = btr_pkg::DEF_GLYPH_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic [btr_pkg::FONT_ADDR_W-1:0] i_font_address,
    input  logic [7:0]                      i_font_byte,
    input  logic [7:0]                      i_char_code,
    input  logic                            i_first_of_string,
    input  logic [7:0]                      i_origin_x,
    input  logic [7:0]                      i_origin_y,
    input  logic [15:0]                     i_background,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [15:0]                     o_pixel_index,
    output logic [15:0]                     o_pixel_value,
    output logic                            o_write_enable,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [btr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    btr_pkg::t_dp_cmd    w_cmd;
    btr_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    btr_ctrl #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    btr_dp #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_COUNT  (GLYPH_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_font_address    (i_font_address),
        .i_font_byte       (i_font_byte),
        .i_char_code       (i_char_code),
        .i_first_of_string (i_first_of_string),
        .i_origin_x        (i_origin_x),
        .i_origin_y        (i_origin_y),
        .i_background      (i_background),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pixel_index     (o_pixel_index),
        .o_pixel_value     (o_pixel_value),
        .o_write_enable    (o_write_enable),
        .o_last            (o_last)
    );

endmodule

// ===== tb/sv/tb_bitmap_text_renderer_unit.sv =====
module tb_bitmap_text_renderer_unit;

    localparam int GLYPH_W = btr_pkg::DEF_GLYPH_WIDTH;
    localparam int GLYPH_H = btr_pkg::DEF_GLYPH_HEIGHT;
    localparam int GLYPH_N = btr_pkg::DEF_GLYPH_COUNT;

    localparam int RANDOM_ITEMS = 150;
    localparam int PHASE_ITEMS  = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 4_000_000;

    typedef struct packed {
        logic        op;
        logic [9:0]  addr;
        logic [7:0]  fbyte;
        logic [7:0]  code;
        logic        first;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic [15:0] bg;
    } t_text_item;

    typedef struct packed {
        logic [15:0] index;
        logic [15:0] value;
        logic        we;
        logic        last;
    } t_pixel_write;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_operation;
    logic [btr_pkg::FONT_ADDR_W-1:0] i_font_address;
    logic [7:0]                      i_font_byte;
    logic [7:0]                      i_char_code;
    logic                            i_first_of_string;
    logic [7:0]                      i_origin_x;
    logic [7:0]                      i_origin_y;
    logic [15:0]                     i_background;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [15:0]                     o_pixel_index;
    logic [15:0]                     o_pixel_value;
    logic                            o_write_enable;
    logic                            o_last;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [btr_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [btr_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    bitmap_text_renderer_unit dut (.*);

    // Predicted state of the renderer.
    logic [7:0]  font_rom [btr_pkg::STORE_DEPTH];
    bit          rom_written [btr_pkg::STORE_DEPTH];
    int          cur_col = 0;
    int          cur_row = 0;
    int          org_col = 0;
    int          org_row = 0;
    bit          str_on = 1'b0;
    logic [15:0] fg_reg = btr_pkg::RST_FG_COLOR;
    int          img_w = btr_pkg::RST_IMAGE_WIDTH;
    int          img_h = btr_pkg::RST_IMAGE_HEIGHT;

    t_pixel_write pending_pixels[$];
    t_pixel_write due_pixel;
    int           error_count = 0;
    int           work_done = 0;
    int           cycle_count = 0;
    bit           steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_text_renderer_unit verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Receiver back-pressure.
    initial begin
        int g;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(posedge i_clk);
            g = pick_gap();
            if (g > 0) begin
                @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat (g - 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel write: index %h value %h", o_pixel_index,
                       o_pixel_value);
                error_count = error_count + 1;
            end else begin
                due_pixel = pending_pixels.pop_front();
                if (o_pixel_index !== due_pixel.index) begin
                    $error("pixel_index: expected %h, got %h", due_pixel.index,
                           o_pixel_index);
                    error_count = error_count + 1;
                end
                if (o_pixel_value !== due_pixel.value) begin
                    $error("pixel_value: expected %h, got %h", due_pixel.value,
                           o_pixel_value);
                    error_count = error_count + 1;
                end
                if (o_write_enable !== due_pixel.we) begin
                    $error("write_enable: expected %b, got %b", due_pixel.we,
                           o_write_enable);
                    error_count = error_count + 1;
                end
                if (o_last !== due_pixel.last) begin
                    $error("last: expected %b, got %b", due_pixel.last, o_last);
                    error_count = error_count + 1;
                end
            end
        end
    end

    function automatic bit store_font_byte(input t_text_item it);
        if (it.addr >= btr_pkg::STORE_DEPTH) return 1'b0;
        font_rom[it.addr] = it.fbyte;
        rom_written[it.addr] = 1'b1;
        return 1'b1;
    endfunction

    // Places one character and queues its pixel writes; returns 0 when dropped.
    function automatic bit predict_glyph_pixels(input t_text_item it);
        int          gi;
        int          addr;
        int          x;
        int          y;
        bit          glyph_ok;
        bit          row_ok;
        logic [7:0]  bits;
        logic [15:0] colour;
        t_pixel_write px;
        if (it.first) begin
            if (it.ox >= img_w || it.oy >= img_h) begin
                str_on = 1'b0;
                return 1'b0;
            end
            org_col = it.ox;
            org_row = it.oy;
            cur_col = it.ox;
            cur_row = it.oy;
            str_on = 1'b1;
        end else if (!str_on) begin
            return 1'b0;
        end
        if (cur_col + GLYPH_W > img_w) begin
            cur_col = org_col;
            cur_row = (cur_row + GLYPH_H) & 'h1ff;
        end
        if (cur_row + GLYPH_H > img_h) begin
            cur_col = org_col;
            cur_row = org_row;
        end
        gi = int'(it.code) - int'(btr_pkg::FIRST_CODE);
        glyph_ok = gi >= 0 && gi < GLYPH_N;
        if (!glyph_ok) gi = 0;
        for (int r = 0; r < GLYPH_H; r++) begin
            addr = gi * GLYPH_H + r;
            row_ok = glyph_ok && addr < btr_pkg::STORE_DEPTH;
            bits = row_ok ? font_rom[addr] : 8'h00;
            for (int c = 0; c < GLYPH_W; c++) begin
                colour = bits[7 - c] ? fg_reg : it.bg;
                x = cur_col + c;
                y = cur_row + r;
                px.index = 16'(x + y * img_w);
                px.value = {colour[7:0], colour[15:8]};
                px.we = row_ok && x < img_w && y < img_h;
                px.last = (r == GLYPH_H - 1) && (c == GLYPH_W - 1);
                pending_pixels.push_back(px);
            end
        end
        cur_col = (cur_col + GLYPH_W) & 'h1ff;
        return 1'b1;
    endfunction

    function automatic bit glyph_loaded(input logic [7:0] code);
        for (int r = 0; r < GLYPH_H; r++)
            if (!rom_written[(int'(code) - int'(btr_pkg::FIRST_CODE)) * GLYPH_H + r])
                return 1'b0;
        return 1'b1;
    endfunction

    // Mostly loaded glyphs; the rest are codes outside the font.
    function automatic logic [7:0] pick_code();
        logic [7:0] code;
        if ($urandom_range(0, 99) < 20)
            return $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                        : 8'($urandom_range(128, 255));
        do code = 8'($urandom_range(32, 127)); while (!glyph_loaded(code));
        return code;
    endfunction

    function automatic logic [7:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'($urandom_range(1, 7));
        if (r < 27) return 8'd255;
        if (r < 35) return 8'd8;
        return 8'($urandom_range(9, 254));
    endfunction

    function automatic t_text_item random_item();
        t_text_item  it;
        logic [31:0] r0;
        logic [31:0] r1;
        r0 = $urandom;
        r1 = $urandom;
        it.op    = r0[0];
        it.addr  = r0[10:1];
        it.fbyte = r0[18:11];
        it.code  = r0[26:19];
        it.first = r0[27];
        it.ox    = r1[7:0];
        it.oy    = r1[15:8];
        it.bg    = r1[31:16];
        return it;
    endfunction

    function automatic t_text_item load_item(input logic [9:0] addr, input logic [7:0] fbyte);
        t_text_item it;
        it = random_item();
        it.op = btr_pkg::OP_LOAD;
        it.addr = addr;
        it.fbyte = fbyte;
        return it;
    endfunction

    function automatic t_text_item char_item(input logic [7:0] code, input logic first,
                                             input logic [7:0] ox, input logic [7:0] oy,
                                             input logic [15:0] bg);
        t_text_item it;
        it = random_item();
        it.op = btr_pkg::OP_DRAW;
        it.code = code;
        it.first = first;
        it.ox = ox;
        it.oy = oy;
        it.bg = bg;
        return it;
    endfunction

    // Called at a clock edge; returns at the edge of the transfer. Valid stays
    // high until the next call or wait_idle lowers it in that same step.
    task automatic send_item(input t_text_item it);
        int g;
        bit made;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_operation       <= it.op;
        i_font_address    <= it.addr;
        i_font_byte       <= it.fbyte;
        i_char_code       <= it.code;
        i_first_of_string <= it.first;
        i_origin_x        <= it.ox;
        i_origin_y        <= it.oy;
        i_background      <= it.bg;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.op == btr_pkg::OP_LOAD) made = store_font_byte(it);
        else made = predict_glyph_pixels(it);
        if (made) work_done++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // A dropped character may still be in flight after the last pixel.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [btr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            btr_pkg::CFG_FG_COLOR:     fg_reg = data;
            btr_pkg::CFG_IMAGE_WIDTH:  img_w = data[7:0];
            btr_pkg::CFG_IMAGE_HEIGHT: img_h = data[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_glyph(input logic [7:0] code, input int style);
        logic [7:0] b;
        int         base;
        base = (int'(code) - int'(btr_pkg::FIRST_CODE)) * GLYPH_H;
        for (int r = 0; r < GLYPH_H; r++) begin
            case (style)
                0:       b = 8'($urandom);
                1:       b = 8'h00;
                2:       b = 8'hff;
                default: b = (8'h80 >> r) | (8'h01 << r);
            endcase
            send_item(load_item(10'(base + r), b));
        end
    endtask

    // A continuation character right after reset has no string to join.
    task automatic test_idle_string();
        send_item(char_item(8'h41, 1'b0, 8'd0, 8'd0, 16'h1234));
    endtask

    task automatic test_font_load();
        load_glyph(8'h20, 1);
        load_glyph(8'h21, 3);
        load_glyph(8'h41, 0);
        load_glyph(8'h5f, 0);
        load_glyph(8'h7e, 0);
        load_glyph(8'h7f, 2);
        send_item(load_item(10'd767, 8'h5a));
        // Addresses past the store are ignored.
        send_item(load_item(10'd768, 8'hff));
        send_item(load_item(10'h3ff, 8'h00));
    endtask

    task automatic test_glyph_codes();
        send_item(char_item(8'h20, 1'b1, 8'd0, 8'd0, 16'hffff));
        send_item(char_item(8'h7f, 1'b0, 8'd0, 8'd0, 16'h0000));
        send_item(char_item(8'h1f, 1'b0, 8'd0, 8'd0, 16'ha5c3));
        send_item(char_item(8'h80, 1'b0, 8'd0, 8'd0, 16'h00ff));
        send_item(char_item(8'h00, 1'b0, 8'd0, 8'd0, 16'hff00));
        send_item(char_item(8'hff, 1'b0, 8'd0, 8'd0, 16'h5a3c));
        wait_idle();
        write_reg(btr_pkg::CFG_FG_COLOR, 16'hffff);
        send_item(char_item(8'h21, 1'b1, 8'd16, 8'd8, 16'h0000));
        wait_idle();
        write_reg(btr_pkg::CFG_FG_COLOR, 16'h12ab);
    endtask

    task automatic test_cursor_edges();
        // The glyph fits exactly, then the next one wraps to a new line.
        send_item(char_item(8'h41, 1'b1, 8'd120, 8'd0, 16'h0f0f));
        send_item(char_item(8'h41, 1'b0, 8'd0, 8'd0, 16'h0f0f));
        // The origin is too close to the right edge: pixels spill outside.
        send_item(char_item(8'h21, 1'b1, 8'd121, 8'd0, 16'h3333));
        // Bottom right corner: the second glyph returns to the origin.
        send_item(char_item(8'h7e, 1'b1, 8'd120, 8'd120, 16'h4444));
        send_item(char_item(8'h7e, 1'b0, 8'd0, 8'd0, 16'h5555));
        send_item(char_item(8'h5f, 1'b1, 8'd0, 8'd121, 16'h6666));
    endtask

    task automatic test_invalid_origin();
        send_item(char_item(8'h41, 1'b1, 8'd128, 8'd0, 16'h7777));
        send_item(char_item(8'h41, 1'b0, 8'd0, 8'd0, 16'h7777));
        send_item(char_item(8'h41, 1'b1, 8'd0, 8'd255, 16'h8888));
        send_item(char_item(8'h41, 1'b1, 8'd255, 8'd255, 16'h9999));
    endtask

    task automatic test_geometry_extremes();
        wait_idle();
        write_reg(btr_pkg::CFG_IMAGE_WIDTH, 16'h0001);
        write_reg(btr_pkg::CFG_IMAGE_HEIGHT, 16'h0001);
        send_item(char_item(8'h7f, 1'b1, 8'd0, 8'd0, 16'hc0de));
        send_item(char_item(8'h21, 1'b0, 8'd0, 8'd0, 16'hc0de));
        wait_idle();
        write_reg(btr_pkg::CFG_IMAGE_WIDTH, 16'h00ff);
        write_reg(btr_pkg::CFG_IMAGE_HEIGHT, 16'h00ff);
        // Coordinates past 255 make the index overflow 16 bits.
        send_item(char_item(8'h41, 1'b1, 8'd250, 8'd250, 16'hbeef));
        send_item(char_item(8'h7f, 1'b0, 8'd0, 8'd0, 16'hbeef));
        send_item(char_item(8'h20, 1'b1, 8'd254, 8'd254, 16'hffff));
        send_item(char_item(8'h20, 1'b1, 8'd255, 8'd0, 16'hffff));
    endtask

    task automatic test_random_text();
        int         goal;
        int         phase_end;
        int         phase;
        int         r;
        logic [7:0] ox;
        logic [7:0] oy;
        goal = work_done + RANDOM_ITEMS;
        phase = 0;
        while (work_done < goal) begin
            wait_idle();
            steady = (phase % 4 == 3);
            write_reg(btr_pkg::CFG_FG_COLOR, 16'($urandom));
            write_reg(btr_pkg::CFG_IMAGE_WIDTH, {8'($urandom), pick_dim()});
            write_reg(btr_pkg::CFG_IMAGE_HEIGHT, {8'($urandom), pick_dim()});
            phase_end = work_done + PHASE_ITEMS;
            while (work_done < phase_end && work_done < goal) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    load_glyph(8'($urandom_range(32, 127)), $urandom_range(0, 3));
                end else if (r < 13) begin
                    send_item(load_item(10'($urandom), 8'($urandom)));
                end else if (r < 22) begin
                    if ($urandom_range(0, 1)) begin
                        ox = 8'($urandom);
                        oy = 8'($urandom);
                        if ($urandom_range(0, 1)) ox = 8'($urandom_range(img_w, 255));
                        else oy = 8'($urandom_range(img_h, 255));
                        send_item(char_item(pick_code(), 1'b1, ox, oy, 16'($urandom)));
                        repeat ($urandom_range(0, 3))
                            send_item(char_item(pick_code(), 1'b0, 8'($urandom),
                                                8'($urandom), 16'($urandom)));
                    end else begin
                        send_item(char_item(pick_code(), 1'b0, 8'($urandom),
                                            8'($urandom), 16'($urandom)));
                    end
                end else begin
                    ox = 8'($urandom_range(0, img_w - 1));
                    oy = 8'($urandom_range(0, img_h - 1));
                    send_item(char_item(pick_code(), 1'b1, ox, oy, 16'($urandom)));
                    repeat ($urandom_range(0, 10))
                        send_item(char_item(pick_code(), 1'b0, 8'($urandom),
                                            8'($urandom), 16'($urandom)));
                end
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_operation       = btr_pkg::OP_LOAD;
        i_font_address    = '0;
        i_font_byte       = '0;
        i_char_code       = '0;
        i_first_of_string = 1'b0;
        i_origin_x        = '0;
        i_origin_y        = '0;
        i_background      = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = btr_pkg::CFG_FG_COLOR;
        i_cfg_data        = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_string();
        test_font_load();
        test_glyph_codes();
        test_cursor_edges();
        test_invalid_origin();
        test_geometry_extremes();
        test_random_text();

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (error_count == 0)
            $display("bitmap_text_renderer_unit verification clean");
        else
            $display("bitmap_text_renderer_unit verification failed");
        $finish;
    end

endmodule
